/* src/lru_read_through_cache_core_assert.svh */
// Assertion macros for the LRU cache core.
`ifndef LRU_READ_THROUGH_CACHE_CORE_ASSERT_SVH
`define LRU_READ_THROUGH_CACHE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked on the rising clock edge, off while reset is asserted.
`define LRC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on the rising clock edge, also during reset.
`define LRC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LRC_ASSERT(label, clk, rst_n, prop, msg)
`define LRC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* src/lrc_pkg.sv */
package lrc_pkg;

    localparam int ENTRIES_DEF     = 16;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 64;

    // capacity register
    localparam int             CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_FILL   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic latch_req;
        logic do_match;
        logic do_update;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

/* src/lrc_if.sv */
interface lrc_req_if #(
    parameter int KEY_WIDTH   = lrc_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = lrc_pkg::VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] fill_value;

    modport source (output valid, command, key, fill_value, input ready);
    modport sink   (input valid, command, key, fill_value, output ready);
endinterface

interface lrc_rsp_if #(
    parameter int KEY_WIDTH   = lrc_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = lrc_pkg::VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [VALUE_WIDTH-1:0] value;
    logic                   evicted;
    logic [KEY_WIDTH-1:0]   evicted_key;

    modport source (output valid, hit, value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, value, evicted, evicted_key, output ready);
endinterface

/* src/lrc_ctrl.sv */
`include "lru_read_through_cache_core_assert.svh"

module lrc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  lrc_pkg::t_dp_status i_status,
    output lrc_pkg::t_dp_cmd    o_cmd
);

    lrc_pkg::t_state r_state;
    lrc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lrc_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = lrc_pkg::ST_MATCH;
                end
            end
            lrc_pkg::ST_MATCH: begin
                n_state = lrc_pkg::ST_UPDATE;
            end
            lrc_pkg::ST_UPDATE: begin
                n_state = lrc_pkg::ST_RESULT;
            end
            lrc_pkg::ST_RESULT: begin
                // hold until the output register can take the word
                if (i_status.out_free) begin
                    n_state = lrc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            lrc_pkg::ST_IDLE: begin
                o_req_ready     = 1'b1;
                o_cmd.latch_req = i_req_valid;
            end
            lrc_pkg::ST_MATCH: begin
                o_cmd.do_match = 1'b1;
            end
            lrc_pkg::ST_UPDATE: begin
                o_cmd.do_update = 1'b1;
            end
            lrc_pkg::ST_RESULT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    `LRC_ASSERT(a_result_waits, i_clk, i_rst_n, (r_state == lrc_pkg::ST_RESULT && !i_status.out_free) |=> (r_state == lrc_pkg::ST_RESULT), "result state left while output register busy")
    `LRC_ASSERT(a_accept_starts_match, i_clk, i_rst_n, (i_req_valid && o_req_ready) |=> (r_state == lrc_pkg::ST_MATCH), "accepted word did not start a compare")

endmodule

/* src/lrc_datapath.sv */
`include "lru_read_through_cache_core_assert.svh"

module lrc_datapath #(
    parameter int ENTRIES     = lrc_pkg::ENTRIES_DEF,
    parameter int KEY_WIDTH   = lrc_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = lrc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lrc_pkg::t_dp_cmd           i_cmd,
    output lrc_pkg::t_dp_status        o_status,
    input  logic                       i_cfg_we,
    input  logic [lrc_pkg::CAP_W-1:0]  i_cfg_wdata,
    input  logic                       i_req_command,
    input  logic [KEY_WIDTH-1:0]       i_req_key,
    input  logic [VALUE_WIDTH-1:0]     i_req_fill_value,
    output logic                       o_rsp_valid,
    input  logic                       i_rsp_ready,
    output logic                       o_rsp_hit,
    output logic [VALUE_WIDTH-1:0]     o_rsp_value,
    output logic                       o_rsp_evicted,
    output logic [KEY_WIDTH-1:0]       o_rsp_evicted_key
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = (CW > lrc_pkg::CAP_W) ? CW : lrc_pkg::CAP_W;

    // configuration
    logic [lrc_pkg::CAP_W-1:0] r_capacity;

    // entry cells
    logic [ENTRIES-1:0]   r_valid;
    logic [KEY_WIDTH-1:0] r_key [ENTRIES];
    logic [IW-1:0]        r_rank [ENTRIES];
    logic [CW-1:0]        r_count;

    // value store
    logic [VALUE_WIDTH-1:0] mem [ENTRIES];
    logic [VALUE_WIDTH-1:0] r_rd_data;

    // latched request
    logic                   r_cmd;
    logic [KEY_WIDTH-1:0]   r_req_key;
    logic [VALUE_WIDTH-1:0] r_fill;

    // compare results
    logic [ENTRIES-1:0] r_match;
    logic               r_hit;
    logic [IW-1:0]      r_hit_idx;
    logic [IW-1:0]      r_hit_rank;

    // pending result
    logic                 r_res_hit;
    logic                 r_res_evicted;
    logic [KEY_WIDTH-1:0] r_res_evkey;

    // output register
    logic                   r_out_valid;
    logic                   r_out_hit;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic                   r_out_evicted;
    logic [KEY_WIDTH-1:0]   r_out_evkey;

    // combinational
    logic [ENTRIES-1:0]   c_match;
    logic [IW-1:0]        c_hit_idx;
    logic [IW-1:0]        c_hit_rank;
    logic [EW-1:0]        c_cap_ext;
    logic [CW-1:0]        c_cap;
    logic [CW-1:0]        c_cap_m1;
    logic [CW-1:0]        c_cnt_m1;
    logic                 c_full;
    logic                 c_insert;
    logic [ENTRIES-1:0]   c_drop;
    logic [ENTRIES-1:0]   c_keep;
    logic [IW-1:0]        c_slot;
    logic [KEY_WIDTH-1:0] c_evkey;
    logic [IW-1:0]        c_wr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lrc_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_cmd     <= i_req_command;
            r_req_key <= i_req_key;
            r_fill    <= i_req_fill_value;
        end
    end

    // key compare against every cell
    always_comb begin
        c_hit_idx  = '0;
        c_hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            c_match[i] = r_valid[i] && (r_key[i] == r_req_key);
            if (c_match[i]) begin
                c_hit_idx  = c_hit_idx | IW'(i);
                c_hit_rank = c_hit_rank | r_rank[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_match) begin
            r_match    <= c_match;
            r_hit      <= |c_match;
            r_hit_idx  <= c_hit_idx;
            r_hit_rank <= c_hit_rank;
        end
    end

    // effective capacity: zero reads as one, clipped to the entry count
    always_comb begin
        c_cap_ext = EW'(r_capacity);
        if (c_cap_ext == '0) begin
            c_cap = CW'(1);
        end else if (c_cap_ext > EW'(ENTRIES)) begin
            c_cap = CW'(ENTRIES);
        end else begin
            c_cap = CW'(c_cap_ext);
        end
        c_cap_m1 = c_cap - CW'(1);
        c_cnt_m1 = r_count - CW'(1);
        c_full   = (r_count >= c_cap);
        c_insert = (r_cmd == lrc_pkg::CMD_FILL) && !r_hit;
    end

    // eviction drops every rank at or past capacity-1; the oldest is reported
    always_comb begin
        c_evkey = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            c_drop[i] = c_full && r_valid[i] && (CW'(r_rank[i]) >= c_cap_m1);
            if (r_valid[i] && (CW'(r_rank[i]) == c_cnt_m1)) begin
                c_evkey = c_evkey | r_key[i];
            end
        end
        c_keep = r_valid & ~c_drop;
    end

    // lowest free cell after the drop
    always_comb begin
        c_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!c_keep[i]) begin
                c_slot = IW'(i);
            end
        end
        c_wr_addr = r_hit ? r_hit_idx : c_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.do_update) begin
            if (r_hit) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_match[i]) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                        r_rank[i] <= r_rank[i] + IW'(1);
                    end
                end
            end else if (c_insert) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (c_slot == IW'(i)) begin
                        r_valid[i] <= 1'b1;
                        r_rank[i]  <= '0;
                    end else begin
                        r_valid[i] <= c_keep[i];
                        if (c_keep[i]) begin
                            r_rank[i] <= r_rank[i] + IW'(1);
                        end
                    end
                end
                r_count <= c_full ? c_cap : r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_update && c_insert) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (c_slot == IW'(i)) begin
                    r_key[i] <= r_req_key;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_update) begin
            if (r_cmd == lrc_pkg::CMD_FILL) begin
                mem[c_wr_addr] <= r_fill;
            end
            r_rd_data <= mem[r_hit_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_update) begin
            r_res_hit     <= r_hit && (r_cmd == lrc_pkg::CMD_LOOKUP);
            r_res_evicted <= c_insert && c_full;
            r_res_evkey   <= (c_insert && c_full) ? c_evkey : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_hit     <= r_res_hit;
            r_out_value   <= r_res_hit ? r_rd_data : '0;
            r_out_evicted <= r_res_evicted;
            r_out_evkey   <= r_res_evkey;
        end
    end

    assign o_status.out_free = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid       = r_out_valid;
    assign o_rsp_hit         = r_out_hit;
    assign o_rsp_value       = r_out_value;
    assign o_rsp_evicted     = r_out_evicted;
    assign o_rsp_evicted_key = r_out_evkey;

    `LRC_ASSERT(a_count_tracks_valid, i_clk, i_rst_n, $countones(r_valid) == int'(r_count), "fill count differs from number of valid cells")
    `LRC_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CW'(ENTRIES), "fill count above entry count")
    `LRC_ASSERT(a_single_match, i_clk, i_rst_n, i_cmd.do_match |-> $onehot0(c_match), "key present in more than one cell")
    `LRC_ASSERT(a_hit_not_evict, i_clk, i_rst_n, i_cmd.load_out |-> !(r_res_hit && r_res_evicted), "result marks both hit and eviction")

endmodule

/* src/lru_read_through_cache_core.sv */
// Fully associative key/value cache with least-recently-used replacement.
// A lookup word returns hit and the stored value and makes the entry most
// recent; a miss returns all zeros. A fill word stores the value; for a key
// not present it first evicts the least recent entry when the cache holds
// capacity entries and reports that key. Capacity (i_cfg_wdata, written by
// i_cfg_we while idle; the user must keep to that, the block does not enforce
// it) is clipped to 1..ENTRIES and resets to 16. Each word goes from accept
// through compare, age/value update with the registered value-store read and
// output load, in the controller sequence; one word is in flight at a time,
// so a new word is accepted only once the previous result has loaded. The
// next word is accepted while the previous result waits in the output
// register; a result that cannot load holds the controller until the output
// register frees. Valid bits clear at reset, with no clearing pass.
module lru_read_through_cache_core #(
    parameter int ENTRIES     = lrc_pkg::ENTRIES_DEF,
    parameter int KEY_WIDTH   = lrc_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = lrc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lrc_pkg::CAP_W-1:0] i_cfg_wdata,
    lrc_req_if.sink                   i_req,
    lrc_rsp_if.source                 o_rsp
);

    lrc_pkg::t_dp_cmd    cmd;
    lrc_pkg::t_dp_status status;

    lrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lrc_datapath #(
        .ENTRIES     (ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_req_command     (i_req.command),
        .i_req_key         (i_req.key),
        .i_req_fill_value  (i_req.fill_value),
        .o_rsp_valid       (o_rsp.valid),
        .i_rsp_ready       (o_rsp.ready),
        .o_rsp_hit         (o_rsp.hit),
        .o_rsp_value       (o_rsp.value),
        .o_rsp_evicted     (o_rsp.evicted),
        .o_rsp_evicted_key (o_rsp.evicted_key)
    );

endmodule
